// ----- hw/rtl/smx_pkg.sv -----
`default_nettype none

package smx_pkg;

   // word and field widths
   localparam int DATA_W       = 32;
   localparam int CODE_LEN_W   = 16;
   localparam int DEPTH_OUT_W  = 11;
   localparam int PC_CMP_W     = 33;   // holds any counter width plus one

   // parameter defaults
   localparam int STACK_DEPTH_DEF = 1024;
   localparam int PC_BITS_DEF     = 16;

   localparam logic [CODE_LEN_W-1:0] CODE_LEN_RESET = 16'hFFFF;

   // opcodes
   localparam logic [3:0] OP_HALT   = 4'd0;
   localparam logic [3:0] OP_ADD    = 4'd1;
   localparam logic [3:0] OP_POP    = 4'd2;
   localparam logic [3:0] OP_PUSH   = 4'd3;
   localparam logic [3:0] OP_SUB    = 4'd4;
   localparam logic [3:0] OP_DIV    = 4'd5;
   localparam logic [3:0] OP_MUL    = 4'd6;
   localparam logic [3:0] OP_PRINT  = 4'd7;
   localparam logic [3:0] OP_BRANCH = 4'd8;

   // fault codes
   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_UNDERFLOW = 2'd1;
   localparam logic [1:0] FAULT_OVERFLOW  = 2'd2;
   localparam logic [1:0] FAULT_DIV_ZERO  = 2'd3;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic               out_valid;
      logic signed [31:0] out_value;
      logic               halted;
      logic [1:0]         fault;
      logic [10:0]        depth_now;
   } rsp_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DIV  = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/stack_machine_executor.sv -----
// Stack machine execute unit.
// req channel: one fetched instruction per item (opcode, immediate), taken when
//   req_valid is high and req_stall is low. req_stall is high while an item
//   is being executed.
// rsp channel: exactly one result item per instruction (next pc, popped value,
//   halted flag, fault code, stack depth), held in an output register and
//   taken when rsp_valid is high and rsp_stall is low.
// csr channel: writes code_length; csr_ready is always high. Write only while
//   the unit is idle.
// Timing: the stack RAM is read on the accept edge and written back together
//   with the result register once the output register is free, so the next
//   item is taken after write-back. DIV first runs the one-bit-per-cycle
//   divider: start, 32 steps, then write-back.
// When the receiver stalls, the finished result waits in the output register;
//   the unit still takes one more item and holds its write-back until the
//   output register frees up.
// Reset (synchronous): empty stack, pc 0, running, code_length 65535. Stack
//   RAM contents are not cleared; only entries below the depth are used.
`default_nettype none

module stack_machine_executor #(
   parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
   parameter int PC_BITS     = smx_pkg::PC_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire smx_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output smx_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [smx_pkg::CODE_LEN_W-1:0] csr_data
);

   localparam int W      = smx_pkg::DATA_W;
   localparam int CW     = smx_pkg::PC_CMP_W;
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] PC_MAX_C = (CW'(1) << PC_BITS) - CW'(1);

   smx_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]               count_ff, count_in;
   logic [PC_BITS-1:0]             pc_ff, pc_in;
   logic                           halt_ff, halt_in;
   logic [smx_pkg::CODE_LEN_W-1:0] code_len_ff;
   logic [3:0]                     op_ff;
   logic [W-1:0]                   imm_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   smx_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                           accept;
   logic                           out_free;
   logic                           commit;
   logic                           div_start;

   logic [W-1:0]                   val_a;
   logic [W-1:0]                   val_b;
   logic [W-1:0]                   quotient;
   smx_pkg::div_stat_type          div_stat;

   // execution results
   logic [CW-1:0]                  pc_c;
   logic [CW-1:0]                  len_c;
   logic [CW-1:0]                  inc1_c;
   logic [CW-1:0]                  inc2_c;
   logic [CW-1:0]                  imm_c;
   logic [CW-1:0]                  npc_c;
   logic [W-1:0]                   cnt32;
   logic                           e_halt;
   logic [1:0]                     e_fault;
   logic                           e_valid;
   logic [W-1:0]                   e_value;
   logic [CNT_W-1:0]               e_count;
   logic                           e_we;
   logic [ADDR_W-1:0]              e_waddr;
   logic [W-1:0]                   e_wdata;
   logic                           div_need;
   logic [W-1:0]                   alu_r;
   logic [W-1:0]                   fin_cnt32;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != smx_pkg::S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         code_len_ff <= smx_pkg::CODE_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         code_len_ff <= csr_data;
      end
   end

   // instruction latch
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_data.opcode;
         imm_ff <= req_data.operand;
      end
   end

   // operand stack, top two entries read at accept
   smx_stack_ram #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (e_we && commit),
      .wr_addr   (e_waddr),
      .wr_data   (e_wdata),
      .rd_en     (accept),
      .rd_addr_a (ADDR_W'(count_ff - CNT_W'(1))),
      .rd_addr_b (ADDR_W'(count_ff - CNT_W'(2))),
      .rd_data_a (val_a),
      .rd_data_b (val_b)
   );

   smx_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (val_b),
      .divisor  (val_a),
      .quotient (quotient),
      .status   (div_stat)
   );

   // arithmetic result for the two-operand opcodes
   always_comb begin
      unique case (op_ff)
         smx_pkg::OP_ADD: alu_r = val_b + val_a;
         smx_pkg::OP_SUB: alu_r = val_b - val_a;
         smx_pkg::OP_MUL: alu_r = val_b * val_a;
         default:         alu_r = quotient;
      endcase
   end

   // execute the latched instruction against the current state
   always_comb begin
      pc_c     = CW'(pc_ff);
      len_c    = CW'(code_len_ff);
      inc1_c   = ((pc_c + CW'(1)) > PC_MAX_C) ? PC_MAX_C : (pc_c + CW'(1));
      inc2_c   = ((pc_c + CW'(2)) > PC_MAX_C) ? PC_MAX_C : (pc_c + CW'(2));
      imm_c    = CW'(imm_ff);
      cnt32    = W'(count_ff);
      npc_c    = pc_c;
      e_halt   = halt_ff;
      e_fault  = smx_pkg::FAULT_NONE;
      e_valid  = 1'b0;
      e_value  = '0;
      e_count  = count_ff;
      e_we     = 1'b0;
      e_waddr  = ADDR_W'(count_ff);
      e_wdata  = imm_ff;
      div_need = 1'b0;
      if (halt_ff || (pc_c >= len_c)) begin
         e_halt = 1'b1;
      end else begin
         npc_c = inc1_c;
         unique case (op_ff) inside
            smx_pkg::OP_HALT: begin
               e_halt = 1'b1;
               npc_c  = pc_c;
            end
            smx_pkg::OP_PUSH: begin
               npc_c = inc2_c;
               if (cnt32 >= W'(STACK_DEPTH)) begin
                  e_fault = smx_pkg::FAULT_OVERFLOW;
               end else begin
                  e_we    = 1'b1;
                  e_count = count_ff + CNT_W'(1);
               end
            end
            smx_pkg::OP_POP: begin
               if (cnt32 == W'(0)) begin
                  e_fault = smx_pkg::FAULT_UNDERFLOW;
               end else begin
                  e_count = count_ff - CNT_W'(1);
                  e_value = val_a;
                  e_valid = 1'b1;
               end
            end
            smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV: begin
               if (cnt32 < W'(2)) begin
                  e_fault = smx_pkg::FAULT_UNDERFLOW;
               end else if ((op_ff == smx_pkg::OP_DIV) && (val_a == '0)) begin
                  e_fault = smx_pkg::FAULT_DIV_ZERO;
               end else begin
                  div_need = (op_ff == smx_pkg::OP_DIV);
                  e_we     = 1'b1;
                  e_waddr  = ADDR_W'(count_ff - CNT_W'(2));
                  e_wdata  = alu_r;
                  e_count  = count_ff - CNT_W'(1);
               end
            end
            smx_pkg::OP_BRANCH: begin
               if (imm_ff[W-1] || (imm_c > PC_MAX_C)) begin
                  npc_c = PC_MAX_C;
               end else begin
                  npc_c = imm_c;
               end
            end
            default: begin
               npc_c = inc1_c;
            end
         endcase
         if (npc_c >= len_c) begin
            e_halt = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      commit    = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         smx_pkg::S_IDLE: begin
            if (accept) begin
               state_in = smx_pkg::S_EXEC;
            end
         end
         smx_pkg::S_EXEC: begin
            if (div_need) begin
               div_start = 1'b1;
               state_in  = smx_pkg::S_DIV;
            end else if (out_free) begin
               commit   = 1'b1;
               state_in = smx_pkg::S_IDLE;
            end
         end
         smx_pkg::S_DIV: begin
            if (div_stat.done && out_free) begin
               commit   = 1'b1;
               state_in = smx_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = smx_pkg::S_IDLE;
         end
      endcase
   end

   // architectural state update on write-back
   always_comb begin
      count_in = count_ff;
      pc_in    = pc_ff;
      halt_in  = halt_ff;
      if (commit) begin
         count_in = e_count;
         pc_in    = PC_BITS'(npc_c);
         halt_in  = e_halt;
      end
   end

   // result register
   always_comb begin
      fin_cnt32             = W'(e_count);
      rsp_data_in           = rsp_data_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      if (commit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.next_pc   = (npc_c > CW'(16'hFFFF)) ? 16'hFFFF : npc_c[15:0];
         rsp_data_in.out_valid = e_valid;
         rsp_data_in.out_value = e_value;
         rsp_data_in.halted    = e_halt;
         rsp_data_in.fault     = e_fault;
         rsp_data_in.depth_now = fin_cnt32[smx_pkg::DEPTH_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smx_pkg::S_IDLE;
         count_ff     <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/smx_stack_ram.sv -----
`default_nettype none

module smx_stack_ram #(
   parameter int DEPTH  = smx_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_W = $clog2(smx_pkg::STACK_DEPTH_DEF)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [smx_pkg::DATA_W-1:0]  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr_a,
   input  wire logic [ADDR_W-1:0]           rd_addr_b,
   output logic      [smx_pkg::DATA_W-1:0]  rd_data_a,
   output logic      [smx_pkg::DATA_W-1:0]  rd_data_b
);

   logic [smx_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [smx_pkg::DATA_W-1:0] rd_a_ff;
   logic [smx_pkg::DATA_W-1:0] rd_b_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // two registered read ports, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/smx_divider.sv -----
`default_nettype none

module smx_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [smx_pkg::DATA_W-1:0]  dividend,
   input  wire logic [smx_pkg::DATA_W-1:0]  divisor,
   output logic      [smx_pkg::DATA_W-1:0]  quotient,
   output smx_pkg::div_stat_type            status
);

   localparam int W     = smx_pkg::DATA_W;
   localparam int CNT_W = $clog2(W);

   logic [W-1:0]     rem_ff,  rem_in;
   logic [W-1:0]     quo_ff,  quo_in;
   logic [W-1:0]     dvs_ff,  dvs_in;
   logic             neg_ff,  neg_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [W:0]       rem_shift;
   logic [W:0]       diff;

   // one restoring step per cycle on magnitudes, sign fixed at the end
   always_comb begin
      rem_shift = {rem_ff, quo_ff[W-1]};
      diff      = rem_shift - {1'b0, dvs_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[W-1] ? (W'(0) - dividend) : dividend;
         dvs_in  = divisor[W-1]  ? (W'(0) - divisor)  : divisor;
         neg_in  = dividend[W-1] ^ divisor[W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // remainder stays below the divisor magnitude, so W bits hold it
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign quotient    = neg_ff ? (W'(0) - quo_ff) : quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/smx_checker.sv -----
`default_nettype none

module smx_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire smx_pkg::req_type               req_data,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire smx_pkg::rsp_type               rsp_data,
   input wire logic                           csr_valid,
   input wire logic                           csr_ready,
   input wire logic [smx_pkg::CODE_LEN_W-1:0] csr_data
);

   logic unused_ok;
   assign unused_ok = ^{req_data, csr_valid, csr_ready, csr_data};

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result item changed while stalled");

   // one item in flight: no accept on the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while previous still executing");

   // a new result only appears while an item was executing
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item without an executing instruction");

   // halted is sticky: a result item right after a taken halted item is halted too
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.halted) |=> (!rsp_valid || rsp_data.halted))
      else $error("machine left the halted state");

endmodule

bind stack_machine_executor smx_checker u_smx_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);

`default_nettype wire
